@@ design/hrp_pkg.sv @@
// Package for the HTTP request header parser: codes, word types and character classes.
`default_nettype none
package hrp_pkg;

	localparam int VERSION_BITS_DEF = 16;
	localparam int VER_OUT_W        = 16;
	localparam int STATE_W          = 5;

	localparam logic [STATE_W-1:0] ST_METHOD_START       = 5'd0;
	localparam logic [STATE_W-1:0] ST_METHOD             = 5'd1;
	localparam logic [STATE_W-1:0] ST_URI                = 5'd2;
	localparam logic [STATE_W-1:0] ST_VER_H              = 5'd3;
	localparam logic [STATE_W-1:0] ST_VER_T1             = 5'd4;
	localparam logic [STATE_W-1:0] ST_VER_T2             = 5'd5;
	localparam logic [STATE_W-1:0] ST_VER_P              = 5'd6;
	localparam logic [STATE_W-1:0] ST_VER_SLASH          = 5'd7;
	localparam logic [STATE_W-1:0] ST_MAJOR_START        = 5'd8;
	localparam logic [STATE_W-1:0] ST_MAJOR              = 5'd9;
	localparam logic [STATE_W-1:0] ST_MINOR_START        = 5'd10;
	localparam logic [STATE_W-1:0] ST_MINOR              = 5'd11;
	localparam logic [STATE_W-1:0] ST_NL1                = 5'd12;
	localparam logic [STATE_W-1:0] ST_LINE_START         = 5'd13;
	localparam logic [STATE_W-1:0] ST_LWS                = 5'd14;
	localparam logic [STATE_W-1:0] ST_NAME               = 5'd15;
	localparam logic [STATE_W-1:0] ST_SPACE_BEFORE_VALUE = 5'd16;
	localparam logic [STATE_W-1:0] ST_VALUE              = 5'd17;
	localparam logic [STATE_W-1:0] ST_NL2                = 5'd18;
	localparam logic [STATE_W-1:0] ST_NL3                = 5'd19;

	localparam logic [1:0] STAT_MORE = 2'd0;
	localparam logic [1:0] STAT_DONE = 2'd1;
	localparam logic [1:0] STAT_BAD  = 2'd2;

	localparam logic [2:0] KIND_DELIM    = 3'd0;
	localparam logic [2:0] KIND_METHOD   = 3'd1;
	localparam logic [2:0] KIND_URI      = 3'd2;
	localparam logic [2:0] KIND_NEW_NAME = 3'd3;
	localparam logic [2:0] KIND_NAME     = 3'd4;
	localparam logic [2:0] KIND_VALUE    = 3'd5;

	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_HT    = 8'h09;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'd127;
	localparam logic [7:0] CH_CTL_MAX = 8'd31;

	typedef struct packed {
		logic               bad;
		logic [1:0]         status;
		logic [2:0]         kind;
		logic [STATE_W-1:0] next_state;
		logic               hdr_seen;
	} step_ctl_t;

	function automatic logic is_ctl(input logic [7:0] b);
		return (b <= CH_CTL_MAX) || (b == CH_DEL);
	endfunction

	function automatic logic is_sep(input logic [7:0] b);
		logic r;
		case (b)
			8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
			8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic is_token(input logic [7:0] b);
		return !b[7] && !is_ctl(b) && !is_sep(b);
	endfunction

	function automatic logic is_dec_char(input logic [7:0] b);
		return b inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_lws(input logic [7:0] b);
		return (b == CH_SP) || (b == CH_HT);
	endfunction

endpackage
`default_nettype wire

@@ design/hrp_step.sv @@
// One parser step: next state, status, field tag and version accumulators for one byte.
`default_nettype none
module hrp_step #(
	parameter int VERSION_BITS = hrp_pkg::VERSION_BITS_DEF
) (
	input  wire logic [hrp_pkg::STATE_W-1:0] state,
	input  wire logic                        hdr_seen,
	input  wire logic [VERSION_BITS-1:0]     major,
	input  wire logic [VERSION_BITS-1:0]     minor,
	input  wire logic [7:0]                  b,
	output hrp_pkg::step_ctl_t               ctl,
	output logic      [VERSION_BITS-1:0]     major_next,
	output logic      [VERSION_BITS-1:0]     minor_next
);
	import hrp_pkg::*;

	localparam int AW = VERSION_BITS + 4;

	function automatic logic [VERSION_BITS-1:0] acc_digit(
		input logic [VERSION_BITS-1:0] acc,
		input logic [7:0]              d
	);
		logic [AW-1:0] w;
		logic [AW-1:0] v;
		w = AW'(acc);
		v = (w << 3) + (w << 1) + AW'(d[3:0]);
		if (v > AW'({VERSION_BITS{1'b1}}))
			return {VERSION_BITS{1'b1}};
		return v[VERSION_BITS-1:0];
	endfunction

	logic               bad;
	logic [1:0]         stat;
	logic [2:0]         kind;
	logic [STATE_W-1:0] nxt;
	logic               seen_nxt;
	logic [VERSION_BITS-1:0] maj_nxt;
	logic [VERSION_BITS-1:0] min_nxt;

	always_comb begin
		bad      = 1'b0;
		stat     = STAT_MORE;
		kind     = KIND_DELIM;
		nxt      = state;
		seen_nxt = hdr_seen;
		maj_nxt  = major;
		min_nxt  = minor;
		case (state)
			ST_METHOD_START: begin
				if (is_token(b)) begin
					nxt  = ST_METHOD;
					kind = KIND_METHOD;
				end else
					bad = 1'b1;
			end
			ST_METHOD: begin
				if (b == CH_SP)        nxt = ST_URI;
				else if (is_token(b))  kind = KIND_METHOD;
				else                   bad = 1'b1;
			end
			ST_URI: begin
				if (b == CH_SP)        nxt = ST_VER_H;
				else if (is_ctl(b))    bad = 1'b1;
				else                   kind = KIND_URI;
			end
			ST_VER_H: begin
				if (b == CH_H) nxt = ST_VER_T1; else bad = 1'b1;
			end
			ST_VER_T1: begin
				if (b == CH_T) nxt = ST_VER_T2; else bad = 1'b1;
			end
			ST_VER_T2: begin
				if (b == CH_T) nxt = ST_VER_P; else bad = 1'b1;
			end
			ST_VER_P: begin
				if (b == CH_P) nxt = ST_VER_SLASH; else bad = 1'b1;
			end
			ST_VER_SLASH: begin
				if (b == CH_SLASH) begin
					maj_nxt = '0;
					min_nxt = '0;
					nxt     = ST_MAJOR_START;
				end else
					bad = 1'b1;
			end
			ST_MAJOR_START: begin
				if (is_dec_char(b)) begin
					maj_nxt = acc_digit(major, b);
					nxt     = ST_MAJOR;
				end else
					bad = 1'b1;
			end
			ST_MAJOR: begin
				if (b == CH_DOT)          nxt = ST_MINOR_START;
				else if (is_dec_char(b))  maj_nxt = acc_digit(major, b);
				else                      bad = 1'b1;
			end
			ST_MINOR_START: begin
				if (is_dec_char(b)) begin
					min_nxt = acc_digit(minor, b);
					nxt     = ST_MINOR;
				end else
					bad = 1'b1;
			end
			ST_MINOR: begin
				if (b == CH_CR)           nxt = ST_NL1;
				else if (is_dec_char(b))  min_nxt = acc_digit(minor, b);
				else                      bad = 1'b1;
			end
			ST_NL1: begin
				if (b == CH_LF) nxt = ST_LINE_START; else bad = 1'b1;
			end
			ST_LINE_START: begin
				if (b == CH_CR)
					nxt = ST_NL3;
				else if (hdr_seen && is_lws(b))
					nxt = ST_LWS;
				else if (is_token(b)) begin
					seen_nxt = 1'b1;
					nxt      = ST_NAME;
					kind     = KIND_NEW_NAME;
				end else
					bad = 1'b1;
			end
			ST_LWS: begin
				if (b == CH_CR)
					nxt = ST_NL2;
				else if (is_lws(b))
					nxt = ST_LWS;
				else if (is_ctl(b))
					bad = 1'b1;
				else begin
					nxt  = ST_VALUE;
					kind = KIND_VALUE;
				end
			end
			ST_NAME: begin
				if (b == CH_COLON)     nxt = ST_SPACE_BEFORE_VALUE;
				else if (is_token(b))  kind = KIND_NAME;
				else                   bad = 1'b1;
			end
			ST_SPACE_BEFORE_VALUE: begin
				if (b == CH_SP) nxt = ST_VALUE; else bad = 1'b1;
			end
			ST_VALUE: begin
				if (b == CH_CR)        nxt = ST_NL2;
				else if (is_ctl(b))    bad = 1'b1;
				else                   kind = KIND_VALUE;
			end
			ST_NL2: begin
				if (b == CH_LF) nxt = ST_LINE_START; else bad = 1'b1;
			end
			ST_NL3: begin
				if (b == CH_LF) stat = STAT_DONE; else bad = 1'b1;
			end
			default: begin
				bad = 1'b1;
			end
		endcase

		// a bad byte leaves everything as it was
		if (bad) begin
			stat     = STAT_BAD;
			kind     = KIND_DELIM;
			nxt      = state;
			seen_nxt = hdr_seen;
			maj_nxt  = major;
			min_nxt  = minor;
		end
	end

	assign ctl.bad        = bad;
	assign ctl.status     = stat;
	assign ctl.kind       = kind;
	assign ctl.next_state = nxt;
	assign ctl.hdr_seen   = seen_nxt;
	assign major_next     = maj_nxt;
	assign minor_next     = min_nxt;

endmodule
`default_nettype wire

@@ design/http_request_header_parser_top.sv @@
// HTTP/1.x request line and header parser, one byte per word.
//
// Input channel: in_valid / in_stall with data_byte. Output channel: out_valid /
// out_stall with status, field_kind, byte_out, version_major, version_minor.
// A word moves at a rising edge with valid high and stall low.
// Every input byte gives exactly one output word. A byte is held in an input
// register, the state-machine logic classifies it and updates the parse state and
// version accumulators, and the word lands in the output register.
// Throughput: 1 byte per cycle while the receiver does not stall, set by the
// parse-state update loop.
// When the receiver stalls, the output register holds its word, the input register
// keeps one more byte, and in_stall rises while both are full.
// Reset (arst_n low) returns the parser to the start of the method token, clears the
// version counts and the header-seen flag and empties both registers. After the
// request completes, only reset starts a new one.
// Versions saturate at 2**VERSION_BITS-1 and appear on 16-bit ports (low bits).
`default_nettype none
module http_request_header_parser_top #(
	parameter int VERSION_BITS = hrp_pkg::VERSION_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [7:0]                    data_byte,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [1:0]                         status,
	output logic [2:0]                         field_kind,
	output logic [7:0]                         byte_out,
	output logic [hrp_pkg::VER_OUT_W-1:0]      version_major,
	output logic [hrp_pkg::VER_OUT_W-1:0]      version_minor
);
	import hrp_pkg::*;

	logic                    valid_s1;
	logic [7:0]              byte_s1;
	logic [STATE_W-1:0]      state_q;
	logic                    hdr_seen_q;
	logic [VERSION_BITS-1:0] major_q;
	logic [VERSION_BITS-1:0] minor_q;

	logic [1:0]              status_q;
	logic [2:0]              kind_q;
	logic [7:0]              byte_q;
	logic [VERSION_BITS-1:0] major_out_q;
	logic [VERSION_BITS-1:0] minor_out_q;
	logic                    out_valid_q;

	step_ctl_t               ctl;
	logic [VERSION_BITS-1:0] major_next;
	logic [VERSION_BITS-1:0] minor_next;
	logic                    adv;
	logic                    in_acc;
	logic [31:0]             major_ext;
	logic [31:0]             minor_ext;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;

	hrp_step #(
		.VERSION_BITS(VERSION_BITS)
	) u_step (
		.state     (state_q),
		.hdr_seen  (hdr_seen_q),
		.major     (major_q),
		.minor     (minor_q),
		.b         (byte_s1),
		.ctl       (ctl),
		.major_next(major_next),
		.minor_next(minor_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= ST_METHOD_START;
			hdr_seen_q  <= 1'b0;
			major_q     <= '0;
			minor_q     <= '0;
		end else begin
			if (in_acc)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv) begin
				out_valid_q <= 1'b1;
				state_q     <= ctl.next_state;
				hdr_seen_q  <= ctl.hdr_seen;
				major_q     <= major_next;
				minor_q     <= minor_next;
			end else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			byte_s1 <= data_byte;
		if (adv) begin
			status_q    <= ctl.status;
			kind_q      <= ctl.kind;
			byte_q      <= byte_s1;
			major_out_q <= major_next;
			minor_out_q <= minor_next;
		end
	end

	assign major_ext     = 32'(major_out_q);
	assign minor_ext     = 32'(minor_out_q);
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign field_kind    = kind_q;
	assign byte_out      = byte_q;
	assign version_major = major_ext[VER_OUT_W-1:0];
	assign version_minor = minor_ext[VER_OUT_W-1:0];

	a_bad_no_field: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_BAD |-> field_kind == KIND_DELIM)
		else $error("bad word carries a field tag");

	a_bad_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ctl.bad |=> $stable(state_q) && $stable(major_q) && $stable(minor_q)
			&& $stable(hdr_seen_q))
		else $error("bad byte changed parser state");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		adv && state_q == ST_NL3 |-> ctl.status != STAT_MORE)
		else $error("byte after final CR reported more needed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == STAT_MORE || status == STAT_DONE || status == STAT_BAD)
		else $error("status code out of range");

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the HTTP request line and header parser.
`timescale 1ns / 100ps
module testbench;
	import hrp_pkg::*;

	localparam int CALM_TAIL = 60;
	localparam logic [63:0] VER_LIMIT = (64'd1 << VERSION_BITS_DEF) - 64'd1;

	typedef struct packed {
		logic [STATE_W-1:0] st;
		logic [31:0]        major;
		logic [31:0]        minor;
		logic               seen;
	} parser_t;

	typedef struct packed {
		logic [1:0]  stat;
		logic [2:0]  kind;
		logic [7:0]  data;
		logic [15:0] major;
		logic [15:0] minor;
	} word_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [2:0]  field_kind;
	logic [7:0]  byte_out;
	logic [15:0] version_major;
	logic [15:0] version_minor;

	// bit 8 set: hold the byte back until every expected word has come
	logic [8:0] byte_q[$];
	word_t      expected_words[$];
	parser_t    gen_model;
	parser_t    dut_model;
	word_t      acc_w;
	word_t      exp_w;
	logic [8:0] next_item;
	int         mismatches = 0;
	int         noise_pct = 0;
	int         send_gap;
	int         send_pct;
	logic [5:0] send_tick;
	int         stall_left;
	int         stall_pct;
	logic [5:0] stall_tick;

	http_request_header_parser_top #(
		.VERSION_BITS(VERSION_BITS_DEF)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.field_kind(field_kind),
		.byte_out(byte_out),
		.version_major(version_major),
		.version_minor(version_minor)
	);

	function automatic logic ctl_byte(input logic [7:0] b);
		return (b < 8'd32) || (b == 8'd127);
	endfunction

	function automatic logic token_byte(input logic [7:0] b);
		logic sep;
		case (b)
			"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
			"/", "[", "]", "?", "=", "{", "}", " ", "\t": sep = 1'b1;
			default: sep = 1'b0;
		endcase
		return (b < 8'd128) && !ctl_byte(b) && !sep;
	endfunction

	function automatic logic digit_byte(input logic [7:0] b);
		return (b >= "0") && (b <= "9");
	endfunction

	function automatic logic [31:0] dec_acc(input logic [31:0] acc, input logic [7:0] b);
		logic [63:0] v;
		v = acc * 64'd10 + (b - 8'h30);
		if (v > VER_LIMIT)
			v = VER_LIMIT;
		return v[31:0];
	endfunction

	// one parser step: advances p unless the byte is bad, gives the output word
	task automatic parse_step(inout parser_t p, input logic [7:0] b, output word_t w);
		parser_t            q;
		logic [STATE_W-1:0] nx;
		logic [1:0]         stat;
		logic [2:0]         kind;
		logic               bad;
		q = p;
		nx = p.st;
		stat = STAT_MORE;
		kind = KIND_DELIM;
		bad = 1'b0;
		case (p.st)
			ST_METHOD_START: begin
				if (token_byte(b)) begin
					nx = ST_METHOD;
					kind = KIND_METHOD;
				end else
					bad = 1'b1;
			end
			ST_METHOD: begin
				if (b == CH_SP) nx = ST_URI;
				else if (token_byte(b)) kind = KIND_METHOD;
				else bad = 1'b1;
			end
			ST_URI: begin
				if (b == CH_SP) nx = ST_VER_H;
				else if (ctl_byte(b)) bad = 1'b1;
				else kind = KIND_URI;
			end
			ST_VER_H: if (b == CH_H) nx = ST_VER_T1; else bad = 1'b1;
			ST_VER_T1: if (b == CH_T) nx = ST_VER_T2; else bad = 1'b1;
			ST_VER_T2: if (b == CH_T) nx = ST_VER_P; else bad = 1'b1;
			ST_VER_P: if (b == CH_P) nx = ST_VER_SLASH; else bad = 1'b1;
			ST_VER_SLASH: begin
				if (b == CH_SLASH) begin
					q.major = 32'd0;
					q.minor = 32'd0;
					nx = ST_MAJOR_START;
				end else
					bad = 1'b1;
			end
			ST_MAJOR_START: begin
				if (digit_byte(b)) begin
					q.major = dec_acc(q.major, b);
					nx = ST_MAJOR;
				end else
					bad = 1'b1;
			end
			ST_MAJOR: begin
				if (b == CH_DOT) nx = ST_MINOR_START;
				else if (digit_byte(b)) q.major = dec_acc(q.major, b);
				else bad = 1'b1;
			end
			ST_MINOR_START: begin
				if (digit_byte(b)) begin
					q.minor = dec_acc(q.minor, b);
					nx = ST_MINOR;
				end else
					bad = 1'b1;
			end
			ST_MINOR: begin
				if (b == CH_CR) nx = ST_NL1;
				else if (digit_byte(b)) q.minor = dec_acc(q.minor, b);
				else bad = 1'b1;
			end
			ST_NL1: if (b == CH_LF) nx = ST_LINE_START; else bad = 1'b1;
			ST_LINE_START: begin
				if (b == CH_CR)
					nx = ST_NL3;
				else if (q.seen && (b == CH_SP || b == CH_HT))
					nx = ST_LWS;
				else if (token_byte(b)) begin
					q.seen = 1'b1;
					nx = ST_NAME;
					kind = KIND_NEW_NAME;
				end else
					bad = 1'b1;
			end
			ST_LWS: begin
				if (b == CH_CR)
					nx = ST_NL2;
				else if (b == CH_SP || b == CH_HT)
					nx = ST_LWS;
				else if (ctl_byte(b))
					bad = 1'b1;
				else begin
					nx = ST_VALUE;
					kind = KIND_VALUE;
				end
			end
			ST_NAME: begin
				if (b == CH_COLON) nx = ST_SPACE_BEFORE_VALUE;
				else if (token_byte(b)) kind = KIND_NAME;
				else bad = 1'b1;
			end
			ST_SPACE_BEFORE_VALUE: if (b == CH_SP) nx = ST_VALUE; else bad = 1'b1;
			ST_VALUE: begin
				if (b == CH_CR) nx = ST_NL2;
				else if (ctl_byte(b)) bad = 1'b1;
				else kind = KIND_VALUE;
			end
			ST_NL2: if (b == CH_LF) nx = ST_LINE_START; else bad = 1'b1;
			ST_NL3: if (b == CH_LF) stat = STAT_DONE; else bad = 1'b1;
			default: bad = 1'b1;
		endcase
		if (bad) begin
			stat = STAT_BAD;
			kind = KIND_DELIM;
		end else begin
			q.st = nx;
			p = q;
		end
		w.stat = stat;
		w.kind = kind;
		w.data = b;
		w.major = p.major[15:0];
		w.minor = p.minor[15:0];
	endtask

	function automatic logic [7:0] rand_token();
		logic [7:0] c;
		do
			c = 8'($urandom_range(33, 126));
		while (!token_byte(c));
		return c;
	endfunction

	function automatic logic [7:0] rand_value();
		return ($urandom_range(0, 4) == 0) ? 8'($urandom_range(128, 255))
			: 8'($urandom_range(32, 126));
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic hold);
		word_t      w;
		logic [8:0] item;
		item = {hold, b};
		byte_q = {byte_q, item};
		parse_step(gen_model, b, w);
	endtask

	// a byte that the parser rejects in its current state
	task automatic push_noise();
		parser_t    trial;
		word_t      w;
		logic [7:0] cand;
		logic [7:0] b;
		int         n;
		b = 8'h00;
		for (n = 0; n < 8; n++) begin
			trial = gen_model;
			cand = 8'($urandom_range(0, 255));
			parse_step(trial, cand, w);
			if (w.stat == STAT_BAD) begin
				b = cand;
				break;
			end
		end
		push_byte(b, 1'b0);
	endtask

	task automatic push_good(input logic [7:0] b);
		if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct)
			push_noise();
		push_byte(b, 1'b0);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// input side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= 8'h00;
			send_gap <= 0;
			send_pct <= 0;
			send_tick <= '0;
			dut_model <= '{st: ST_METHOD_START, major: 32'd0, minor: 32'd0, seen: 1'b0};
		end else begin
			if (in_valid && !in_stall) begin
				parse_step(dut_model, data_byte, acc_w);
				expected_words = {expected_words, acc_w};
			end
			send_tick <= send_tick + 6'd1;
			if (send_tick == '0)
				send_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 20);
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (byte_q.size() == 0 || (byte_q[0][8] && expected_words.size() != 0))
					in_valid <= 1'b0;
				else if (byte_q.size() > CALM_TAIL && $urandom_range(0, 99) < send_pct) begin
					send_gap <= $urandom_range(0, 16);
					in_valid <= 1'b0;
				end else begin
					next_item = byte_q.pop_front();
					data_byte <= next_item[7:0];
					in_valid <= 1'b1;
				end
			end
		end
	end

	// output side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			stall_pct <= 0;
			stall_tick <= '0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected word: byte %h status %0d kind %0d",
							byte_out, status, field_kind);
					mismatches++;
				end else begin
					exp_w = expected_words.pop_front();
					if (status !== exp_w.stat || field_kind !== exp_w.kind ||
						byte_out !== exp_w.data || version_major !== exp_w.major ||
						version_minor !== exp_w.minor) begin
						if (mismatches < 10)
							$display({"mismatch (exp/got): status %0d/%0d kind %0d/%0d ",
								"byte %h/%h major %0d/%0d minor %0d/%0d"},
								exp_w.stat, status, exp_w.kind, field_kind,
								exp_w.data, byte_out, exp_w.major, version_major,
								exp_w.minor, version_minor);
						mismatches++;
					end
				end
			end
			stall_tick <= stall_tick + 6'd1;
			if (stall_tick == '0)
				stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 20);
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else if (byte_q.size() > CALM_TAIL && $urandom_range(0, 99) < stall_pct) begin
				stall_left <= $urandom_range(0, 16);
				out_stall <= 1'b1;
			end else
				out_stall <= 1'b0;
		end
	end

	initial begin
		int line;
		int k;
		gen_model = '{st: ST_METHOD_START, major: 32'd0, minor: 32'd0, seen: 1'b0};

		// request line, with rejects in the first states and a saturating major
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(CH_SP, 1'b0);
		repeat ($urandom_range(1, 6)) push_byte(rand_token(), 1'b0);
		push_byte(CH_DEL, 1'b0);
		push_byte(CH_SP, 1'b0);
		push_byte(CH_SLASH, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'hFF, 1'b0);
		repeat ($urandom_range(0, 4)) push_byte(rand_token(), 1'b0);
		push_byte(CH_DEL, 1'b0);
		push_byte(8'h1F, 1'b0);
		push_byte(CH_SP, 1'b0);
		push_byte("X", 1'b0);
		push_byte(CH_H, 1'b0);
		push_byte(CH_T, 1'b0);
		push_byte(CH_T, 1'b0);
		push_byte(CH_P, 1'b0);
		push_byte(CH_SLASH, 1'b0);
		push_byte(CH_DOT, 1'b0);
		for (k = 1; k <= 7; k++)
			push_byte(8'(8'h30 + k), 1'b0);
		push_byte(CH_DOT, 1'b0);
		repeat ($urandom_range(1, 3)) push_byte(8'(8'h30 + $urandom_range(0, 9)), 1'b0);
		push_byte(CH_CR, 1'b0);
		push_byte("A", 1'b0);
		push_byte(CH_LF, 1'b0);
		// folding before any header is a reject
		push_byte(CH_SP, 1'b0);
		push_byte(CH_HT, 1'b0);

		// header lines with folded continuations and scattered rejects
		noise_pct = 6;
		line = 0;
		while (byte_q.size() < 620) begin
			if (line % 17 == 5)
				push_byte(rand_token(), 1'b1);
			else
				push_good(rand_token());
			repeat ($urandom_range(0, 9)) push_good(rand_token());
			push_good(CH_COLON);
			push_good(CH_SP);
			repeat ($urandom_range(0, 20)) push_good(rand_value());
			push_good(CH_CR);
			push_good(CH_LF);
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 3)) push_good($urandom_range(0, 1) ? CH_SP : CH_HT);
				repeat ($urandom_range(0, 15)) push_good(rand_value());
				push_good(CH_CR);
				push_good(CH_LF);
			end
			line++;
		end

		// empty line ends the request; afterwards only LF is accepted
		push_good(CH_CR);
		push_good(CH_LF);
		push_byte(CH_LF, 1'b0);
		push_byte("A", 1'b0);
		push_byte(CH_CR, 1'b0);
		push_byte(CH_LF, 1'b0);

		do
			@(posedge clk);
		while (!arst_n || byte_q.size() != 0 || in_valid || expected_words.size() != 0);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
